[design/contiguous_page_bitmap_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous page bitmap allocator
// Clocked, reset-qualified property wrappers used by the allocator module.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cpba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cpba assertion failed");

`endif

[design/cpba_pkg.sv]
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types and constants of the contiguous page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

    localparam int CNT_W         = 13;   // page_count width
    localparam int PAGE_W        = 12;   // page_base / alloc_page width
    localparam int DEF_NUM_PAGES = 4096;
    localparam int DEF_WORD_BITS = 64;
    localparam int SCAN_CHUNK    = 8;    // bits examined per scan step

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_e;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FAIL = 1'b1
    } status_e;

    typedef struct packed {
        cmd_e              command;
        logic [CNT_W-1:0]  page_count;
        logic [PAGE_W-1:0] page_base;
    } in_item_t;

    typedef struct packed {
        status_e           status;
        logic [PAGE_W-1:0] alloc_page;
    } out_item_t;

    // result of one scan step over a chunk of a bitmap word
    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] run;
    } scan_res_t;

endpackage

[design/contiguous_page_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// Used/free page bitmap with top-down first-fit run allocation and run free.
// ----------------------------------------------------------------------------
// One item at a time; s_ready is high only while the sequencer idles. After
// reset a clearing pass writes every bitmap word once and reserves page 0;
// no item is taken meanwhile. Allocate scans words from the top of the map
// through one memory read port: a word that is all used or all free is
// settled as soon as it has been read, while a mixed word goes on through the
// shared run scanner, 8 bits per step; the run is then written back word by
// word as a read-modify-write. Free walks words from page 0, stepping past
// the words below the base and doing a read-modify-write on each word it
// touches. The result goes out through an output register.
// ----------------------------------------------------------------------------
`include "contiguous_page_bitmap_allocator_defines.svh"

module contiguous_page_bitmap_allocator
    import cpba_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BI_W      = $clog2(WORD_BITS);
    localparam int AW_A      = $clog2(NUM_PAGES + WORD_BITS) + 1;
    localparam int AW        = (AW_A > CNT_W + 1) ? AW_A : CNT_W + 1;
    localparam int LAST_BITS = NUM_PAGES - (MAP_WORDS - 1) * WORD_BITS;

    localparam logic [WI_W-1:0]      LAST_WORD = WI_W'(MAP_WORDS - 1);
    localparam logic [AW-1:0]        LAST_WS   = AW'((MAP_WORDS - 1) * WORD_BITS);
    localparam logic [AW-1:0]        WB        = AW'(WORD_BITS);
    localparam logic [AW-1:0]        MAX_PAGE  = AW'(NUM_PAGES - 1);
    localparam logic [WORD_BITS-1:0] ONES      = '1;
    // pages past the end of the space in the last word read as used
    localparam logic [WORD_BITS-1:0] TAIL_MASK = ~(ONES >> (WORD_BITS - LAST_BITS));
    localparam logic [WORD_BITS-1:0] WORD0_INIT = WORD_BITS'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_SCAN_CHUNK,
        S_FILL_CHK,
        S_FILL_WR,
        S_DONE
    } state_t;

    // bitmap memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en, wr_en;
    logic [WI_W-1:0]      rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // sequencer
    state_t           state_reg, state_next;
    logic [WI_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [WI_W-1:0]  word_idx_reg, word_idx_next;   // scan goes down, fill goes up
    logic [AW-1:0]    ws_reg, ws_next;               // first page of word_idx
    logic [CNT_W-1:0] run_reg, run_next;
    logic [BI_W-1:0]  bc_reg, bc_next;
    cmd_e             cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW-1:0]    end_reg, end_next;             // last page of the run
    out_item_t        pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;

    logic [WORD_BITS-1:0] eff_word;
    scan_res_t            scan_res;
    logic [BI_W-1:0]      found_bit;

    assign eff_word = rd_data_reg | ((word_idx_reg == LAST_WORD) ? TAIL_MASK : '0);

    cpba_run_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_run_scan (
        .word_i      (eff_word),
        .bc_i        (bc_reg),
        .run_i       (run_reg),
        .count_i     (count_reg),
        .res_o       (scan_res),
        .found_bit_o (found_bit)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        logic [AW-1:0]        cnt_ext;
        logic [AW-1:0]        sum;
        logic [AW-1:0]        fbase;
        logic [BI_W-1:0]      lo_off, hi_off;
        logic [WORD_BITS-1:0] mask;
        cnt_ext = AW'(count_reg);
        sum     = '0;
        fbase   = '0;
        lo_off  = '0;
        hi_off  = '0;
        mask    = '0;

        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        word_idx_next = word_idx_reg;
        ws_next       = ws_reg;
        run_next      = run_reg;
        bc_next       = bc_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        end_next      = end_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;

        rd_en   = 1'b0;
        rd_addr = word_idx_reg;
        wr_en   = 1'b0;
        wr_addr = word_idx_reg;
        wr_data = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = (clr_idx_reg == '0) ? WORD0_INIT : '0;
                if (clr_idx_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_item.command;
                    count_next = s_item.page_count;
                    cnt_ext    = AW'(s_item.page_count);
                    if (s_item.command == CMD_ALLOC) begin
                        pend_next.status     = ST_FAIL;
                        pend_next.alloc_page = '0;
                        if (cnt_ext == '0 || cnt_ext > AW'(NUM_PAGES)) begin
                            state_next = S_DONE;
                        end else begin
                            word_idx_next = LAST_WORD;
                            ws_next       = LAST_WS;
                            run_next      = '0;
                            state_next    = S_SCAN_RD;
                        end
                    end else begin
                        // free: clip the run to the space, start from page 0
                        pend_next.status     = ST_OK;
                        pend_next.alloc_page = '0;
                        base_next = AW'(s_item.page_base);
                        sum       = AW'(s_item.page_base) + cnt_ext - 1'b1;
                        end_next  = (sum > MAX_PAGE) ? MAX_PAGE : sum;
                        word_idx_next = '0;
                        ws_next       = '0;
                        if (cnt_ext == '0 || AW'(s_item.page_base) > MAX_PAGE) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_FILL_CHK;
                        end
                    end
                end
            end

            S_SCAN_RD: begin
                rd_en      = 1'b1;
                rd_addr    = word_idx_reg;
                state_next = S_SCAN_EVAL;
            end

            S_SCAN_EVAL: begin
                if (&eff_word) begin
                    run_next = '0;
                    if (word_idx_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        word_idx_next = word_idx_reg - 1'b1;
                        ws_next       = ws_reg - WB;
                        state_next    = S_SCAN_RD;
                    end
                end else if (eff_word == '0) begin
                    if (AW'(run_reg) + WB < cnt_ext) begin
                        run_next = CNT_W'(AW'(run_reg) + WB);
                        if (word_idx_reg == '0) begin
                            state_next = S_DONE;
                        end else begin
                            word_idx_next = word_idx_reg - 1'b1;
                            ws_next       = ws_reg - WB;
                            state_next    = S_SCAN_RD;
                        end
                    end else begin
                        // run completes inside this all-free word
                        fbase     = ws_reg + WB - (cnt_ext - AW'(run_reg));
                        base_next = fbase;
                        end_next  = fbase + cnt_ext - 1'b1;
                        pend_next.status     = ST_OK;
                        pend_next.alloc_page = fbase[PAGE_W-1:0];
                        state_next = S_FILL_CHK;
                    end
                end else begin
                    bc_next    = BI_W'(WORD_BITS - 1);
                    state_next = S_SCAN_CHUNK;
                end
            end

            S_SCAN_CHUNK: begin
                run_next = scan_res.run;
                if (scan_res.found) begin
                    fbase     = ws_reg + AW'(found_bit);
                    base_next = fbase;
                    end_next  = fbase + cnt_ext - 1'b1;
                    pend_next.status     = ST_OK;
                    pend_next.alloc_page = fbase[PAGE_W-1:0];
                    state_next = S_FILL_CHK;
                end else if (int'(bc_reg) < SCAN_CHUNK) begin
                    if (word_idx_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        word_idx_next = word_idx_reg - 1'b1;
                        ws_next       = ws_reg - WB;
                        state_next    = S_SCAN_RD;
                    end
                end else begin
                    bc_next = bc_reg - BI_W'(SCAN_CHUNK);
                end
            end

            S_FILL_CHK: begin
                if (ws_reg > end_reg) begin
                    state_next = S_DONE;
                end else if (ws_reg + WB - 1'b1 < base_reg) begin
                    word_idx_next = word_idx_reg + 1'b1;
                    ws_next       = ws_reg + WB;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = word_idx_reg;
                    state_next = S_FILL_WR;
                end
            end

            S_FILL_WR: begin
                lo_off = (base_reg > ws_reg) ? BI_W'(base_reg - ws_reg) : '0;
                hi_off = (end_reg >= ws_reg + WB - 1'b1) ? BI_W'(WORD_BITS - 1)
                                                         : BI_W'(end_reg - ws_reg);
                mask   = (ONES << lo_off) & (ONES >> (BI_W'(WORD_BITS - 1) - hi_off));
                wr_en   = 1'b1;
                wr_addr = word_idx_reg;
                wr_data = (cmd_reg == CMD_ALLOC) ? (rd_data_reg | mask)
                                                 : (rd_data_reg & ~mask);
                word_idx_next = word_idx_reg + 1'b1;
                ws_next       = ws_reg + WB;
                state_next    = S_FILL_CHK;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = pend_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
        word_idx_reg <= word_idx_next;
        ws_reg       <= ws_next;
        run_reg      <= run_next;
        bc_reg       <= bc_next;
        cmd_reg      <= cmd_next;
        count_reg    <= count_next;
        base_reg     <= base_next;
        end_reg      <= end_next;
        pend_reg     <= pend_next;
        m_item_reg   <= m_item_next;
    end

    // no bitmap write outside the clearing pass and the fill step
    `CPBA_ASSERT_SAME(a_write_only_when_busy, aclk, aresetn,
        wr_en, (state_reg == S_CLEAR) || (state_reg == S_FILL_WR))
    // a word being filled never lies past the last page of the run
    `CPBA_ASSERT_SAME(a_fill_in_range, aclk, aresetn,
        state_reg == S_FILL_WR, ws_reg <= end_reg)
    // an allocated run ends inside the space
    `CPBA_ASSERT_SAME(a_alloc_run_fits, aclk, aresetn,
        (state_reg == S_FILL_CHK) && (cmd_reg == CMD_ALLOC), end_reg <= MAX_PAGE)
    // a failed allocate reports page zero
    `CPBA_ASSERT_SAME(a_fail_page_zero, aclk, aresetn,
        m_valid && (m_item.status == ST_FAIL), m_item.alloc_page == '0)

endmodule

[design/cpba_run_scan.sv]
// ----------------------------------------------------------------------------
// cpba_run_scan
// One scan step: walks a chunk of a bitmap word downward, extending or
// restarting the free run, and flags the bit where the run reaches the count.
// ----------------------------------------------------------------------------
module cpba_run_scan
    import cpba_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic [WORD_BITS-1:0]         word_i,
    input  logic [$clog2(WORD_BITS)-1:0] bc_i,       // top bit of this chunk
    input  logic [CNT_W-1:0]             run_i,
    input  logic [CNT_W-1:0]             count_i,
    output scan_res_t                    res_o,
    output logic [$clog2(WORD_BITS)-1:0] found_bit_o
);

    localparam int BI_W = $clog2(WORD_BITS);

    always_comb begin
        logic [CNT_W-1:0] run;
        logic             found;
        logic [BI_W-1:0]  fb;
        logic [BI_W-1:0]  jj;
        run   = run_i;
        found = 1'b0;
        fb    = '0;
        jj    = '0;
        for (int k = 0; k < SCAN_CHUNK; k++) begin
            if (!found && (int'(bc_i) >= k)) begin
                jj = bc_i - BI_W'(k);
                if (word_i[jj]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (run == count_i) begin
                        found = 1'b1;
                        fb    = jj;
                    end
                end
            end
        end
        res_o.found = found;
        res_o.run   = run;
        found_bit_o = fb;
    end

endmodule

[tb/sv/contiguous_page_bitmap_allocator_test.sv]
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_test
// Self-checking bench for the page-run allocator. A shadow bitmap predicts
// every result: top-down first-fit allocate and clipped free. A directed
// pass covers the edge cases. Random traffic follows: allocates, frees of
// live runs and noise. Both ports idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module contiguous_page_bitmap_allocator_test;
    import cpba_pkg::*;

    localparam int NPAGES     = DEF_NUM_PAGES;
    localparam int IDLE_PCT   = 21;       // chance of an idle cycle, each side
    localparam int TAIL_WAIT  = 400;      // cycles after the last result
    localparam int RUN_LIMIT  = 200_000_000; // ns, hard stop

    typedef struct {
        int unsigned base;
        int unsigned count;
    } page_run_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // shadow of the used/free bitmap, bit p set when page p is used
    logic [NPAGES-1:0] pages_in_use;

    out_item_t  expected_results[$];
    page_run_t  live_runs[$];        // runs handed out and not yet freed
    int         error_count = 0;
    bit         no_idle     = 1'b0;  // both sides run flat out while set

    contiguous_page_bitmap_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #10 aclk = ~aclk;

    // run limit; sized well past the slowest legal run
    initial begin
        #(RUN_LIMIT);
        $display("contiguous_page_bitmap_allocator_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------
    function automatic out_item_t predict_page_op(in_item_t it);
        out_item_t   res;
        int unsigned cnt;
        int unsigned run_len;
        int          run_base;
        res.status     = ST_OK;
        res.alloc_page = '0;
        cnt            = it.page_count;
        if (it.command == CMD_ALLOC) begin
            run_base = -1;
            run_len  = 0;
            // zero count and counts past the space can never fit
            if (cnt != 0 && cnt <= NPAGES) begin
                for (int p = NPAGES - 1; p >= 0 && run_base < 0; p--) begin
                    if (pages_in_use[p]) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len == cnt) run_base = p;
                    end
                end
            end
            if (run_base < 0) begin
                res.status = ST_FAIL;   // map left as is
            end else begin
                for (int unsigned q = 0; q < cnt; q++) pages_in_use[run_base + q] = 1'b1;
                res.alloc_page = run_base[PAGE_W-1:0];
            end
        end else begin
            // free: pages past the top of the space drop out
            for (int unsigned q = 0; q < cnt; q++) begin
                if (it.page_base + q < NPAGES) pages_in_use[it.page_base + q] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic in_item_t make_item(cmd_e cmd, int unsigned cnt, int unsigned base);
        in_item_t it;
        it.command    = cmd;
        it.page_count = cnt[CNT_W-1:0];
        it.page_base  = base[PAGE_W-1:0];
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one item per call. Called and returns at a falling edge;
    // valid stays high across back-to-back items.
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it, output out_item_t predicted);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < IDLE_PCT) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: predict now, in acceptance order
        predicted = predict_page_op(it);
        expected_results.push_back(predicted);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and the result check
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_item.status, -1);
            end else begin
                want = expected_results.pop_front();
                if (m_item.status !== want.status)
                    report_mismatch("status", m_item.status, want.status);
                if (m_item.alloc_page !== want.alloc_page)
                    report_mismatch("alloc_page", m_item.alloc_page, want.alloc_page);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // edge cases from a freshly reset map (page 0 reserved)
    task automatic test_directed_edges();
        out_item_t r;
        send_item(make_item(CMD_ALLOC, 0, 0), r);            // zero count fails
        send_item(make_item(CMD_ALLOC, 4096, 0), r);         // page 0 reserved: no fit
        send_item(make_item(CMD_ALLOC, 4095, 12'hfff), r);   // whole free space, base ignored
        send_item(make_item(CMD_ALLOC, 1, 0), r);            // map full
        send_item(make_item(CMD_FREE, 0, 100), r);           // zero-count free
        send_item(make_item(CMD_FREE, 8191, 4000), r);       // free clipped at the top
        send_item(make_item(CMD_ALLOC, 97, 0), r);           // one too many
        send_item(make_item(CMD_ALLOC, 96, 0), r);           // exact fit at the top
        send_item(make_item(CMD_FREE, 1, 0), r);             // free the reserved page
        send_item(make_item(CMD_ALLOC, 1, 0), r);            // lands on page 0
        send_item(make_item(CMD_FREE, 4096, 0), r);          // everything free
        send_item(make_item(CMD_ALLOC, 4096, 0), r);         // whole space
        send_item(make_item(CMD_FREE, 4096, 0), r);
        send_item(make_item(CMD_ALLOC, 4097, 0), r);         // larger than the space
        send_item(make_item(CMD_ALLOC, 8191, 12'h555), r);
        send_item(make_item(CMD_ALLOC, 1, 12'haaa), r);      // top page
        send_item(make_item(CMD_ALLOC, 64, 0), r);           // word-sized run
        send_item(make_item(CMD_ALLOC, 3, 0), r);
        send_item(make_item(CMD_FREE, 1, 4095), r);
        send_item(make_item(CMD_FREE, 1, 4095), r);          // already free
        send_item(make_item(CMD_ALLOC, 2, 0), r);            // hole of one skipped
        send_item(make_item(CMD_FREE, 8191, 12'hfff), r);    // full-width count, top base
        send_item(make_item(CMD_FREE, 4096, 0), r);          // clean slate for random part
    endtask

    function automatic int unsigned pick_alloc_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(1, 16);
        if (r < 80) return $urandom_range(17, 128);
        if (r < 93) return $urandom_range(129, 600);
        if (r < 96) return $urandom_range(601, NPAGES);
        if (r < 98) return 0;
        return $urandom_range(NPAGES + 1, (1 << CNT_W) - 1);
    endfunction

    // allocate / free-live-run traffic with some partial frees and noise
    task automatic test_mixed_traffic(input int n_items);
        out_item_t   r;
        in_item_t    it;
        page_run_t   run;
        int unsigned pick;
        int unsigned idx;
        int unsigned off;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (live_runs.size() != 0 && (pick < 32 || $countones(pages_in_use) > 3200)) begin
                // free a live run, now and then only part of it
                idx = $urandom_range(0, live_runs.size() - 1);
                run = live_runs[idx];
                live_runs.delete(idx);
                if ($urandom_range(0, 9) == 0 && run.count > 1) begin
                    off = $urandom_range(0, run.count - 1);
                    it  = make_item(CMD_FREE, $urandom_range(1, run.count - off),
                                    run.base + off);
                end else begin
                    it = make_item(CMD_FREE, run.count, run.base);
                end
                send_item(it, r);
            end else if (pick < 40) begin
                // noise free: random base, mostly short, sometimes any width
                if ($urandom_range(0, 3) == 0)
                    it = make_item(CMD_FREE, $urandom_range(0, (1 << CNT_W) - 1), $urandom);
                else
                    it = make_item(CMD_FREE, $urandom_range(0, 64), $urandom);
                send_item(it, r);
            end else begin
                it = make_item(CMD_ALLOC, pick_alloc_count(), $urandom);
                send_item(it, r);
                if (r.status == ST_OK) begin
                    run.base  = r.alloc_page;
                    run.count = it.page_count;
                    live_runs.push_back(run);
                end
            end
        end
    endtask

    // both sides flat out
    task automatic test_back_to_back(input int n_items);
        no_idle = 1'b1;
        test_mixed_traffic(n_items);
        no_idle = 1'b0;
    endtask

    // sender holds off until the block has delivered everything
    task automatic test_drain_pause(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            test_mixed_traffic(1);
            s_valid <= 1'b0;
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        pages_in_use    = '0;
        pages_in_use[0] = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_edges();
        test_mixed_traffic(450);
        test_drain_pause(30);
        test_back_to_back(300);
        test_mixed_traffic(450);

        s_valid <= 1'b0;
        wait_for_results();
        repeat (TAIL_WAIT) @(posedge aclk);

        if (expected_results.size() != 0)
            report_mismatch("results still owed", 0, expected_results.size());
        if (error_count == 0) begin
            $display("contiguous_page_bitmap_allocator_test: PASS");
        end else begin
            $display("contiguous_page_bitmap_allocator_test: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/cpba_pkg.sv
design/cpba_run_scan.sv
design/contiguous_page_bitmap_allocator.sv
tb/sv/contiguous_page_bitmap_allocator_test.sv
